// ===== src/phong_pixel_shader_top_assert.svh =====
// ----------------------------------------------------------------------------
// phong_pixel_shader_top_assert
// Assertion macros for the Phong shader top level.
// ----------------------------------------------------------------------------
`ifndef PHONG_PIXEL_SHADER_TOP_ASSERT_SVH
`define PHONG_PIXEL_SHADER_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define PHONG_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("phong shader: same-cycle implication failed");

// Next-cycle implication, checked during reset too.
`define PHONG_ASSERT_NEXT(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("phong shader: next-cycle implication failed");

`endif

// ===== src/phong_pkg.sv =====
// ----------------------------------------------------------------------------
// phong_pkg
// Word types and fixed-point constants shared by the Phong shader pipeline.
// ----------------------------------------------------------------------------
package phong_pkg;

    localparam int POW_STAGES = 8;
    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [12:0] ONE_Q12 = 13'd4096;

    localparam logic CFG_AMBIENT_LEVEL = 1'b0;
    localparam logic CFG_SPECULAR_GAIN = 1'b1;

    typedef struct packed {
        logic signed [15:0] light_x;
        logic signed [15:0] light_y;
        logic signed [15:0] light_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
        logic [23:0]        base_rgb;
        logic [7:0]         shininess;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_out_word;

    // Word carried through the power stages.
    typedef struct packed {
        logic [14:0] acc;
        logic [14:0] pbase;
        logic [7:0]  shin;
        logic [18:0] kd;
        logic [23:0] base_rgb;
    } t_pow_word;

endpackage

// ===== src/phong_pixel_shader_top.sv =====
// ----------------------------------------------------------------------------
// phong_pixel_shader_top
// Pipeline: geometry stages, then power stages, then mix stages, from input accept to o_valid.
// Throughput: one word per cycle unless a low i_ready stalls the pipe; every stage register has its own valid bit.
// Reset: synchronous active low; empties the pipe, ambient 0, specular gain 1.0.
// ----------------------------------------------------------------------------
`include "phong_pixel_shader_top_assert.svh"

module phong_pixel_shader_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  phong_pkg::t_in_word  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output phong_pkg::t_out_word o_data
);

    localparam int NP = phong_pkg::POW_STAGES;

    logic [12:0] r_ambient_level;
    logic [15:0] r_specular_gain;

    logic                 w_pv   [NP+1];
    logic                 w_prdy [NP+1];
    phong_pkg::t_pow_word w_pw   [NP+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ambient_level <= '0;
            r_specular_gain <= 16'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                phong_pkg::CFG_AMBIENT_LEVEL: r_ambient_level <= i_cfg_data[12:0];
                phong_pkg::CFG_SPECULAR_GAIN: r_specular_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    phong_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (w_pv[0]),
        .i_ready (w_prdy[0]),
        .o_data  (w_pw[0])
    );

    for (genvar g = 0; g < NP; g++) begin : g_pow
        phong_pow u_pow (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_pv[g]),
            .o_ready (w_prdy[g]),
            .i_data  (w_pw[g]),
            .o_valid (w_pv[g+1]),
            .i_ready (w_prdy[g+1]),
            .o_data  (w_pw[g+1])
        );
    end

    phong_mix u_mix (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ambient_level (r_ambient_level),
        .i_specular_gain (r_specular_gain),
        .i_valid         (w_pv[NP]),
        .o_ready         (w_prdy[NP]),
        .i_data          (w_pw[NP]),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_data          (o_data)
    );

    // back-pressure at the input only when the whole pipe is full and blocked
    `PHONG_ASSERT_IMPLY(a_stall_source, i_clk, i_rst_n, !o_ready, o_valid && !i_ready)
    `PHONG_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_valid)

endmodule

// ===== src/phong_geom.sv =====
// ----------------------------------------------------------------------------
// phong_geom
// Five stages: L.N products, L.N sum, reflection, R.V products, R.V sum with clamp of s and kd.
// ----------------------------------------------------------------------------
module phong_geom (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  phong_pkg::t_in_word i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output phong_pkg::t_pow_word o_data
);

    logic [4:0] r_v;
    logic [4:0] w_rdy;

    // stage 1
    logic signed [17:0] r_p1 [3];
    logic signed [15:0] r_l1 [3];
    logic signed [15:0] r_n1 [3];
    logic signed [15:0] r_v1 [3];
    logic [23:0]        r_base1;
    logic [7:0]         r_shin1;
    // stage 2
    logic signed [19:0] r_d2;
    logic signed [15:0] r_l2 [3];
    logic signed [15:0] r_n2 [3];
    logic signed [15:0] r_v2 [3];
    logic [23:0]        r_base2;
    logic [7:0]         r_shin2;
    // stage 3
    logic signed [23:0] r_r3 [3];
    logic signed [19:0] r_d3;
    logic signed [15:0] r_v3 [3];
    logic [23:0]        r_base3;
    logic [7:0]         r_shin3;
    // stage 4
    logic signed [25:0] r_q4 [3];
    logic signed [19:0] r_d4;
    logic [23:0]        r_base4;
    logic [7:0]         r_shin4;
    // stage 5
    phong_pkg::t_pow_word r_out5;

    logic signed [15:0] w_l [3];
    logic signed [15:0] w_n [3];
    logic signed [15:0] w_vw [3];
    logic signed [31:0] w_ln [3];
    logic signed [36:0] w_rn [3];
    logic signed [39:0] w_rv [3];
    logic signed [27:0] w_s;

    assign w_l  = '{i_data.light_x, i_data.light_y, i_data.light_z};
    assign w_n  = '{i_data.normal_x, i_data.normal_y, i_data.normal_z};
    assign w_vw = '{i_data.view_x, i_data.view_y, i_data.view_z};

    // a stage takes a word when it is empty or its word moves on
    assign w_rdy[4] = !r_v[4] || i_ready;
    assign w_rdy[3] = !r_v[3] || w_rdy[4];
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_v[4];
    assign o_data   = r_out5;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ln[i] = w_l[i] * w_n[i];
            w_rn[i] = $signed({r_d2, 1'b0}) * r_n2[i];
            w_rv[i] = r_r3[i] * r_v3[i];
        end
        w_s = 28'(r_q4[0]) + 28'(r_q4[1]) + 28'(r_q4[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
            if (w_rdy[3]) r_v[3] <= r_v[2];
            if (w_rdy[4]) r_v[4] <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_p1[i] <= $signed(w_ln[i][31:14]);
                r_l1[i] <= w_l[i];
                r_n1[i] <= w_n[i];
                r_v1[i] <= w_vw[i];
            end
            r_base1 <= i_data.base_rgb;
            r_shin1 <= i_data.shininess;
        end
        if (w_rdy[1]) begin
            r_d2    <= 20'(r_p1[0]) + 20'(r_p1[1]) + 20'(r_p1[2]);
            r_l2    <= r_l1;
            r_n2    <= r_n1;
            r_v2    <= r_v1;
            r_base2 <= r_base1;
            r_shin2 <= r_shin1;
        end
        if (w_rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_r3[i] <= $signed(w_rn[i][36:14]) - r_l2[i];
            end
            r_d3    <= r_d2;
            r_v3    <= r_v2;
            r_base3 <= r_base2;
            r_shin3 <= r_shin2;
        end
        if (w_rdy[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_q4[i] <= $signed(w_rv[i][39:14]);
            end
            r_d4    <= r_d3;
            r_base4 <= r_base3;
            r_shin4 <= r_shin3;
        end
        if (w_rdy[4]) begin
            // clamp s to 0..1.0, kd to zero from below
            if (w_s < 0) begin
                r_out5.pbase <= '0;
            end else if (w_s > 28'sd16384) begin
                r_out5.pbase <= phong_pkg::ONE_Q14;
            end else begin
                r_out5.pbase <= w_s[14:0];
            end
            r_out5.kd       <= (r_d4 < 0) ? '0 : r_d4[18:0];
            r_out5.acc      <= phong_pkg::ONE_Q14;
            r_out5.shin     <= r_shin4;
            r_out5.base_rgb <= r_base4;
        end
    end

endmodule

// ===== src/phong_pow.sv =====
// ----------------------------------------------------------------------------
// phong_pow
// One square-and-multiply step of s^shininess, low exponent bit first.
// ----------------------------------------------------------------------------
module phong_pow (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  phong_pkg::t_pow_word i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output phong_pkg::t_pow_word o_data
);

    logic                 r_v;
    phong_pkg::t_pow_word r_word;
    logic [29:0]          w_mul;
    logic [29:0]          w_sq;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_data  = r_word;
    assign w_mul   = i_data.acc * i_data.pbase;
    assign w_sq    = i_data.pbase * i_data.pbase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_word.acc      <= i_data.shin[0] ? w_mul[28:14] : i_data.acc;
            r_word.pbase    <= w_sq[28:14];
            // advance to the next exponent bit
            r_word.shin     <= i_data.shin >> 1;
            r_word.kd       <= i_data.kd;
            r_word.base_rgb <= i_data.base_rgb;
        end
    end

endmodule

// ===== src/phong_mix.sv =====
// ----------------------------------------------------------------------------
// phong_mix
// Three stages: specular, diffuse and ambient terms, factor sum, channel scale.
// ----------------------------------------------------------------------------
module phong_mix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [12:0]          i_ambient_level,
    input  logic [15:0]          i_specular_gain,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  phong_pkg::t_pow_word i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output phong_pkg::t_out_word o_data
);

    logic [2:0]  r_v;
    logic [2:0]  w_rdy;

    logic [18:0] r_ks1;
    logic [19:0] r_diff1;
    logic [14:0] r_amb1;
    logic [23:0] r_base1;
    logic [20:0] r_fac2;
    logic [23:0] r_base2;
    phong_pkg::t_out_word r_out3;

    logic [12:0] w_amb;
    logic [12:0] w_wt;
    logic [30:0] w_ks;
    logic [31:0] w_diff;
    logic [28:0] w_ch [3];
    logic [7:0]  w_sat [3];

    assign w_rdy[2] = !r_v[2] || i_ready;
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_v[2];
    assign o_data   = r_out3;

    always_comb begin
        w_amb  = (i_ambient_level > phong_pkg::ONE_Q12) ? phong_pkg::ONE_Q12
                                                        : i_ambient_level;
        w_wt   = phong_pkg::ONE_Q12 - w_amb;
        w_ks   = i_data.acc * i_specular_gain;
        w_diff = w_wt * i_data.kd;
        w_ch[0] = r_base2[23:16] * r_fac2;
        w_ch[1] = r_base2[15:8] * r_fac2;
        w_ch[2] = r_base2[7:0] * r_fac2;
        for (int i = 0; i < 3; i++) begin
            w_sat[i] = (w_ch[i][28:14] > 15'd255) ? 8'd255 : w_ch[i][21:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_ks1   <= w_ks[30:12];
            r_diff1 <= w_diff[31:12];
            r_amb1  <= {w_amb, 2'b00};
            r_base1 <= i_data.base_rgb;
        end
        if (w_rdy[1]) begin
            r_fac2  <= 21'(r_amb1) + 21'(r_diff1) + 21'(r_ks1);
            r_base2 <= r_base1;
        end
        if (w_rdy[2]) begin
            r_out3.out_red   <= w_sat[0];
            r_out3.out_green <= w_sat[1];
            r_out3.out_blue  <= w_sat[2];
        end
    end

endmodule
